// ===== rtl/core/ils_pkg.sv =====
// shared constants, types and helpers for the indexed list store
`timescale 1ns / 1ps

package ils_pkg;

   // list geometry
   localparam int DEPTH     = 16;
   localparam int WORD_BITS = 32;

   // fixed widths of the transaction fields
   localparam int OP_BITS     = 3;
   localparam int INDEX_BITS  = 4;
   localparam int VALUE_BITS  = 32;
   localparam int DATA_BITS   = 32;
   localparam int STATUS_BITS = 2;
   localparam int LENGTH_BITS = 5;

   // derived widths
   localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LEN_BITS = $clog2(DEPTH + 1);
   localparam int CMP_BITS = (INDEX_BITS > LEN_BITS) ? INDEX_BITS : LEN_BITS;

   typedef enum logic [OP_BITS-1:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_READ       = 3'd2,
      OP_WRITE      = 3'd3,
      OP_REMOVE     = 3'd4,
      OP_POP        = 3'd5
   } ils_op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK   = 2'd0,
      ST_ERR  = 2'd1,
      ST_FULL = 2'd2
   } ils_status_type;

   // what one cell does at the next edge
   typedef enum logic [1:0] {
      CELL_HOLD       = 2'd0,
      CELL_LOAD       = 2'd1,
      CELL_FROM_LOWER = 2'd2,
      CELL_FROM_UPPER = 2'd3
   } ils_cell_cmd_type;

   // per-transaction control handed from the decoder to the top level
   typedef struct packed {
      ils_status_type         status;
      logic [LEN_BITS-1:0]    new_count;
      logic                   rd_en;
      logic [IDX_BITS-1:0]    rd_pos;
   } ils_ctl_type;

   // keep only the stored word width of an incoming value
   function automatic logic [WORD_BITS-1:0] fit_word(input logic [VALUE_BITS-1:0] v);
      return WORD_BITS'(v);
   endfunction

   // bring a stored word out to the result field width
   function automatic logic [DATA_BITS-1:0] fit_data(input logic [WORD_BITS-1:0] w);
      return DATA_BITS'(w);
   endfunction

endpackage

// ===== rtl/core/ils_cell.sv =====
// one storage cell of the list chain
`timescale 1ns / 1ps

module ils_cell import ils_pkg::*; (
   input  logic                  clock,
   input  ils_cell_cmd_type      cmd,
   input  logic [WORD_BITS-1:0]  load_word,
   input  logic [WORD_BITS-1:0]  lower_word,
   input  logic [WORD_BITS-1:0]  upper_word,
   output logic [WORD_BITS-1:0]  word
);

   logic [WORD_BITS-1:0] word_ff;
   logic [WORD_BITS-1:0] word_in;

   always_comb begin
      case (cmd)
         CELL_LOAD:       word_in = load_word;
         CELL_FROM_LOWER: word_in = lower_word;
         CELL_FROM_UPPER: word_in = upper_word;
         default:         word_in = word_ff;
      endcase
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

// ===== rtl/core/ils_ctrl.sv =====
// operation decoder: status, new length and per-cell commands
`timescale 1ns / 1ps

module ils_ctrl import ils_pkg::*; (
   input  logic                    go,
   input  logic [OP_BITS-1:0]      op,
   input  logic [INDEX_BITS-1:0]   index,
   input  logic [LEN_BITS-1:0]     count,
   output ils_ctl_type             ctl,
   output ils_cell_cmd_type        cell_cmd [DEPTH]
);

   logic [CMP_BITS-1:0] idx_cmp;
   logic [CMP_BITS-1:0] cnt_cmp;
   logic [CMP_BITS-1:0] pos;
   logic                full;
   logic                ok;
   ils_status_type      status;
   logic [LEN_BITS-1:0] new_count;
   logic                rd_en;
   ils_op_type          op_code;

   assign idx_cmp = CMP_BITS'(index);
   assign cnt_cmp = CMP_BITS'(count);
   assign full    = (count == LEN_BITS'(DEPTH));
   assign op_code = ils_op_type'(op);

   always_comb begin
      status    = ST_OK;
      new_count = count;
      rd_en     = 1'b0;
      pos       = idx_cmp;
      unique case (op_code) inside
         OP_PUSH_BACK, OP_PUSH_FRONT: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               new_count = count + LEN_BITS'(1);
            end
         end
         OP_READ: begin
            if (idx_cmp >= cnt_cmp) begin
               status = ST_ERR;
            end else begin
               rd_en = 1'b1;
            end
         end
         OP_WRITE: begin
            if (idx_cmp >= cnt_cmp) begin
               status = ST_ERR;
            end
         end
         OP_REMOVE: begin
            if (idx_cmp >= cnt_cmp) begin
               status = ST_ERR;
            end else begin
               rd_en     = 1'b1;
               new_count = count - LEN_BITS'(1);
            end
         end
         OP_POP: begin
            if (count == '0) begin
               status = ST_ERR;
            end else begin
               pos       = cnt_cmp - CMP_BITS'(1);
               rd_en     = 1'b1;
               new_count = count - LEN_BITS'(1);
            end
         end
         default: status = ST_ERR;
      endcase
   end

   assign ok = go && (status == ST_OK);

   // each cell decides from its own position
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_cmd[i] = CELL_HOLD;
         if (ok) begin
            unique case (op_code) inside
               OP_PUSH_BACK: begin
                  if (cnt_cmp == CMP_BITS'(i)) cell_cmd[i] = CELL_LOAD;
               end
               OP_PUSH_FRONT: begin
                  if (i == 0) begin
                     cell_cmd[i] = CELL_LOAD;
                  end else if (CMP_BITS'(i) <= cnt_cmp) begin
                     cell_cmd[i] = CELL_FROM_LOWER;
                  end
               end
               OP_WRITE: begin
                  if (idx_cmp == CMP_BITS'(i)) cell_cmd[i] = CELL_LOAD;
               end
               OP_REMOVE, OP_POP: begin
                  if (CMP_BITS'(i) >= pos && CMP_BITS'(i + 1) < cnt_cmp) begin
                     cell_cmd[i] = CELL_FROM_UPPER;
                  end
               end
               default: cell_cmd[i] = CELL_HOLD;
            endcase
         end
      end
   end

   assign ctl.status    = status;
   assign ctl.new_count = new_count;
   assign ctl.rd_en     = rd_en;
   assign ctl.rd_pos    = pos[IDX_BITS-1:0];

endmodule

// ===== rtl/core/indexed_list_store.sv =====
// top level of the indexed list store: cell chain, length register, result register
//
//   channel | ports                                              | direction
//   --------+----------------------------------------------------+-----------
//   request | req_valid req_stall req_op req_index req_value     | in
//   result  | rsp_valid rsp_stall rsp_data rsp_status rsp_length | out
//
// in every transaction all cells shift, load or hold in parallel
// at the accepting edge, and the result appears in the output register after it
// a new transaction is taken in the same cycle the pending result leaves, so the
// sustained rate is one per cycle while the result side does not stall
// reset clears the length and the result valid; stored words stay undefined
// req_stall is high only while a result is held and the result side stalls
`timescale 1ns / 1ps

module indexed_list_store import ils_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [OP_BITS-1:0]       req_op,
   input  logic [INDEX_BITS-1:0]    req_index,
   input  logic [VALUE_BITS-1:0]    req_value,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [DATA_BITS-1:0]     rsp_data,
   output logic [STATUS_BITS-1:0]   rsp_status,
   output logic [LENGTH_BITS-1:0]   rsp_length
);

   // control state
   logic [LEN_BITS-1:0]     count_ff;
   logic [LEN_BITS-1:0]     count_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;

   // result payload
   logic [DATA_BITS-1:0]    rsp_data_ff;
   logic [DATA_BITS-1:0]    rsp_data_in;
   logic [STATUS_BITS-1:0]  rsp_status_ff;
   logic [STATUS_BITS-1:0]  rsp_status_in;

   logic                    req_take;
   logic [WORD_BITS-1:0]    load_word;
   logic [WORD_BITS-1:0]    cell_word [DEPTH];
   ils_cell_cmd_type        cell_cmd  [DEPTH];
   ils_ctl_type             ctl;

   // the request side only waits when a result is parked and blocked
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign load_word = fit_word(req_value);

   ils_ctrl u_ctrl (
      .go       (req_take),
      .op       (req_op),
      .index    (req_index),
      .count    (count_ff),
      .ctl      (ctl),
      .cell_cmd (cell_cmd)
   );

   // the chain: cell i sees its lower neighbour for push front and its
   // upper neighbour for remove and pop; the ends take the incoming word, never used
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [WORD_BITS-1:0] lower_word;
      logic [WORD_BITS-1:0] upper_word;

      if (g == 0) begin : g_first
         assign lower_word = load_word;
      end else begin : g_mid_lo
         assign lower_word = cell_word[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
         assign upper_word = load_word;
      end else begin : g_mid_hi
         assign upper_word = cell_word[g+1];
      end

      ils_cell u_cell (
         .clock      (clock),
         .cmd        (cell_cmd[g]),
         .load_word  (load_word),
         .lower_word (lower_word),
         .upper_word (upper_word),
         .word       (cell_word[g])
      );
   end

   // next values: length and result follow a taken transaction
   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      if (req_take) begin
         count_in      = ctl.new_count;
         rsp_valid_in  = 1'b1;
         rsp_status_in = STATUS_BITS'(ctl.status);
         // word leaving the list is read before the cells move
         rsp_data_in   = ctl.rd_en ? fit_data(cell_word[ctl.rd_pos]) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_length = LENGTH_BITS'(count_ff);

   // length never runs past the capacity
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= LEN_BITS'(DEPTH))
      else $error("list length beyond capacity");

   // a held result reports the length the list has now
   a_length_match : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_length == LENGTH_BITS'(count_ff)))
      else $error("result length differs from list length");

   // full is only reported on a full list
   a_full_when_full : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_BITS'(ST_FULL))
         |-> (count_ff == LEN_BITS'(DEPTH)))
      else $error("full status on a list with room");

   // a rejected transaction leaves the length alone and returns no word
   a_reject_no_change : assert property (@(posedge clock) disable iff (reset)
      (req_take && ctl.status != ST_OK)
         |=> ($stable(count_ff) && rsp_data_ff == '0))
      else $error("rejected transaction changed the list");

endmodule
